// File: sv/tesf_pkg.sv
package tesf_pkg;

  localparam int SMP_W     = 24;
  localparam int ALPHA_W   = 16;
  localparam int WGT_W     = 24;
  localparam int LVL_W     = 32;
  localparam int FC_W      = 25;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd26214;
  localparam logic [WGT_W-1:0]   BW1_RST   = 24'd145636;
  localparam logic [WGT_W-1:0]   BW2_RST   = 24'd247580;
  localparam logic [WGT_W-1:0]   BW3_RST   = 24'd101945;
  localparam logic [WGT_W-1:0]   CW_RST    = 24'd14564;

  // floor(n / 3) = (n * MEAN_RECIP) >> MEAN_SHIFT for n below 2^27
  localparam logic [25:0] MEAN_RECIP = 26'd44739243;
  localparam int          MEAN_SHIFT = 27;

  localparam int FC_MAX = 16777215;
  localparam int FC_MIN = -16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 3'd0,
    CFG_BW1   = 3'd1,
    CFG_BW2   = 3'd2,
    CFG_BW3   = 3'd3,
    CFG_CW    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [FC_W-1:0] forecast;
    logic [1:0]             horizon;
    logic                   too_short;
    logic                   last_result;
  } out_item_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_MEAN,
    MS_L1,
    MS_L2,
    MS_L3,
    MS_BW1,
    MS_BW2,
    MS_BW3,
    MS_CW
  } mul_sel_t;

  // What to do with the registered product
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_L1,
    ACC_L2,
    ACC_L3,
    ACC_MEAN,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD,
    ACC_FIN
  } acc_op_t;

  typedef struct packed {
    logic       take_in;
    logic       hold_we;
    logic       load_held;
    logic [1:0] hold_idx;
    logic       sum_ld;
    logic       mul_en;
    mul_sel_t   mul_sel;
    acc_op_t    acc_op;
    logic       lvl_clr;
    logic       fc_init;
    logic       fc_step;
    logic       out_ld;
    logic       out_err;
    logic [1:0] horizon;
  } dp_cmd_t;

  // Fraction of the Q24.8 mean left by the remainder of the sum over 3
  function automatic logic [7:0] mean_frac(input logic [1:0] rem);
    logic [7:0] frac;
    case (rem)
      2'd1:    frac = 8'd85;
      2'd2:    frac = 8'd171;
      default: frac = 8'd0;
    endcase
    return frac;
  endfunction

endpackage

// File: sv/tesf_ctrl.sv
module tesf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output tesf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_QMUL,
    S_MEAN,
    S_SMUL,
    S_SACC,
    S_FMUL,
    S_FACC,
    S_FINIT,
    S_EMIT,
    S_ERR
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [1:0] rep_r, rep_nxt;
  logic [1:0] fstep_r, fstep_nxt;
  logic [1:0] m_r, m_nxt;
  logic       last_r, last_nxt;
  logic       replay_r, replay_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    rep_nxt       = rep_r;
    fstep_nxt     = fstep_r;
    m_nxt         = m_r;
    last_nxt      = last_r;
    replay_nxt    = replay_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_sel   = tesf_pkg::MS_L1;
    cmd.acc_op    = tesf_pkg::ACC_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          last_nxt    = in_last;
          if (cnt_r != 2'd3) begin
            cmd.hold_we  = 1'b1;
            cmd.hold_idx = cnt_r;
          end
          case (cnt_r)
            2'd3: begin
              lvl_nxt    = 2'd0;
              replay_nxt = 1'b0;
              state_nxt  = S_SMUL;
            end
            2'd2: begin
              cnt_nxt   = 2'd3;
              state_nxt = S_SUM;
            end
            default: begin
              cnt_nxt = cnt_r + 2'd1;
              if (in_last) begin
                cnt_nxt   = 2'd0;
                state_nxt = S_ERR;
              end
            end
          endcase
        end
      end
      S_SUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = S_QMUL;
      end
      S_QMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tesf_pkg::MS_MEAN;
        state_nxt   = S_MEAN;
      end
      S_MEAN: begin
        cmd.acc_op    = tesf_pkg::ACC_MEAN;
        cmd.load_held = 1'b1;
        cmd.hold_idx  = 2'd0;
        rep_nxt       = 2'd0;
        replay_nxt    = 1'b1;
        lvl_nxt       = 2'd0;
        state_nxt     = S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_en = 1'b1;
        case (lvl_r)
          2'd0:    cmd.mul_sel = tesf_pkg::MS_L1;
          2'd1:    cmd.mul_sel = tesf_pkg::MS_L2;
          default: cmd.mul_sel = tesf_pkg::MS_L3;
        endcase
        state_nxt = S_SACC;
      end
      S_SACC: begin
        case (lvl_r)
          2'd0:    cmd.acc_op = tesf_pkg::ACC_L1;
          2'd1:    cmd.acc_op = tesf_pkg::ACC_L2;
          default: cmd.acc_op = tesf_pkg::ACC_L3;
        endcase
        if (lvl_r != 2'd2) begin
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = S_SMUL;
        end else begin
          lvl_nxt = 2'd0;
          if (replay_r && rep_r != 2'd2) begin
            rep_nxt       = rep_r + 2'd1;
            cmd.load_held = 1'b1;
            cmd.hold_idx  = rep_r + 2'd1;
            state_nxt     = S_SMUL;
          end else if (last_r) begin
            fstep_nxt = 2'd0;
            state_nxt = S_FMUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FMUL: begin
        cmd.mul_en = 1'b1;
        case (fstep_r)
          2'd0:    cmd.mul_sel = tesf_pkg::MS_BW1;
          2'd1:    cmd.mul_sel = tesf_pkg::MS_BW2;
          2'd2:    cmd.mul_sel = tesf_pkg::MS_BW3;
          default: cmd.mul_sel = tesf_pkg::MS_CW;
        endcase
        state_nxt = S_FACC;
      end
      S_FACC: begin
        case (fstep_r)
          2'd0:    cmd.acc_op = tesf_pkg::ACC_LOAD;
          2'd1:    cmd.acc_op = tesf_pkg::ACC_SUB;
          2'd2:    cmd.acc_op = tesf_pkg::ACC_ADD;
          default: cmd.acc_op = tesf_pkg::ACC_FIN;
        endcase
        if (fstep_r != 2'd3) begin
          fstep_nxt = fstep_r + 2'd1;
          state_nxt = S_FMUL;
        end else begin
          state_nxt = S_FINIT;
        end
      end
      S_FINIT: begin
        cmd.fc_init = 1'b1;
        m_nxt       = 2'd1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.horizon = m_r;
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.fc_step   = 1'b1;
          out_valid_nxt = 1'b1;
          if (m_r == 2'd3) begin
            cnt_nxt     = 2'd0;
            cmd.lvl_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            m_nxt = m_r + 2'd1;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_err   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      lvl_r       <= 2'd0;
      rep_r       <= 2'd0;
      fstep_r     <= 2'd0;
      m_r         <= 2'd1;
      last_r      <= 1'b0;
      replay_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      rep_r       <= rep_nxt;
      fstep_r     <= fstep_nxt;
      m_r         <= m_nxt;
      last_r      <= last_nxt;
      replay_r    <= replay_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // The third forecast closes the series
  a_series_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && m_r == 2'd3) |=>
      (cnt_r == 2'd0 && state_r == S_IDLE))
    else $error("series did not close after third forecast");

  // The third sample starts level initialization
  a_third_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && cnt_r == 2'd2) |=> (state_r == S_SUM))
    else $error("third sample did not start initialization");

endmodule

// File: sv/tesf_dp.sv
module tesf_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tesf_pkg::dp_cmd_t                    cmd,
  input  tesf_pkg::in_item_t                   in_item,
  input  logic                                 cfg_we,
  input  logic [tesf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tesf_pkg::WGT_W-1:0]           cfg_wdata,
  output tesf_pkg::out_item_t                  out_item
);

  localparam int PROD_W = 62;
  localparam int B_W    = PROD_W - 16;
  localparam int A_W    = 36;
  localparam int F_W    = 48;
  localparam int SUM_W  = 26;

  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);
  localparam logic signed [F_W-1:0]    RND8  = F_W'(128);
  localparam logic signed [F_W-1:0]    FMAX  = F_W'(tesf_pkg::FC_MAX);
  localparam logic signed [F_W-1:0]    FMIN  = F_W'(tesf_pkg::FC_MIN);

  logic [tesf_pkg::ALPHA_W-1:0] alpha_r;
  logic [tesf_pkg::WGT_W-1:0]   bw1_r, bw2_r, bw3_r, cw_r;

  logic [tesf_pkg::SMP_W-1:0]   held_r [3];
  logic [tesf_pkg::SMP_W-1:0]   x_r;
  logic [SUM_W-1:0]             sum_r;
  logic [tesf_pkg::LVL_W-1:0]   l1_r, l2_r, l3_r;
  logic signed [PROD_W-1:0]     prod_r, acc_r;
  logic signed [B_W-1:0]        b_r, c_r;
  logic signed [A_W-1:0]        a_r;
  logic signed [F_W-1:0]        fsum_r, delta_r;
  tesf_pkg::out_item_t          out_r;

  logic [25:0]                  opa;
  logic signed [34:0]           opb;
  logic signed [PROD_W-1:0]     prod;
  logic [32:0]                  d1, d2, d3, da;
  logic [33:0]                  dc;
  logic signed [B_W-1:0]        p16, acc16;
  logic signed [A_W-1:0]        a_nxt;
  logic [23:0]                  q;
  logic [SUM_W-1:0]             rem;
  logic [tesf_pkg::LVL_W-1:0]   mean;
  logic signed [F_W-1:0]        fr;
  logic signed [tesf_pkg::FC_W-1:0] fc_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= tesf_pkg::ALPHA_RST;
      bw1_r   <= tesf_pkg::BW1_RST;
      bw2_r   <= tesf_pkg::BW2_RST;
      bw3_r   <= tesf_pkg::BW3_RST;
      cw_r    <= tesf_pkg::CW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tesf_pkg::CFG_ALPHA: alpha_r <= cfg_wdata[tesf_pkg::ALPHA_W-1:0];
        tesf_pkg::CFG_BW1:   bw1_r   <= cfg_wdata;
        tesf_pkg::CFG_BW2:   bw2_r   <= cfg_wdata;
        tesf_pkg::CFG_BW3:   bw3_r   <= cfg_wdata;
        tesf_pkg::CFG_CW:    cw_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Differences feeding the multiplier
  assign d1 = {1'b0, x_r, 8'h00} - {1'b0, l1_r};
  assign d2 = {1'b0, l1_r} - {1'b0, l2_r};
  assign d3 = {1'b0, l2_r} - {1'b0, l3_r};
  assign dc = {2'b00, l1_r} - {1'b0, l2_r, 1'b0} + {2'b00, l3_r};
  assign da = d2;

  always_comb begin
    case (cmd.mul_sel)
      tesf_pkg::MS_MEAN: begin
        opa = tesf_pkg::MEAN_RECIP;
        opb = $signed({9'b0, sum_r});
      end
      tesf_pkg::MS_L1: begin
        opa = {10'b0, alpha_r};
        opb = 35'($signed(d1));
      end
      tesf_pkg::MS_L2: begin
        opa = {10'b0, alpha_r};
        opb = 35'($signed(d2));
      end
      tesf_pkg::MS_L3: begin
        opa = {10'b0, alpha_r};
        opb = 35'($signed(d3));
      end
      tesf_pkg::MS_BW1: begin
        opa = {2'b0, bw1_r};
        opb = $signed({3'b0, l1_r});
      end
      tesf_pkg::MS_BW2: begin
        opa = {2'b0, bw2_r};
        opb = $signed({3'b0, l2_r});
      end
      tesf_pkg::MS_BW3: begin
        opa = {2'b0, bw3_r};
        opb = $signed({3'b0, l3_r});
      end
      default: begin
        opa = {2'b0, cw_r};
        opb = 35'($signed(dc));
      end
    endcase
  end

  assign prod = $signed({1'b0, opa}) * opb;

  // Round off 16 fraction bits to Q.8, halves up
  assign p16   = B_W'((prod_r + RND16) >>> 16);
  assign acc16 = B_W'((acc_r + RND16) >>> 16);

  assign a_nxt = A_W'($signed(da)) + A_W'($signed({da, 1'b0})) + $signed({4'b0, l3_r});

  // Mean of the three held samples in Q24.8
  assign q    = prod_r[tesf_pkg::MEAN_SHIFT+23:tesf_pkg::MEAN_SHIFT];
  assign rem  = sum_r - ({2'b00, q} + {1'b0, q, 1'b0});
  assign mean = {q, 8'h00} + {24'h0, tesf_pkg::mean_frac(rem[1:0])};

  // Round from Q.8 to an integer and saturate
  assign fr = (fsum_r + RND8) >>> 8;
  always_comb begin
    if (fr > FMAX) begin
      fc_sat = tesf_pkg::FC_W'(FMAX);
    end else if (fr < FMIN) begin
      fc_sat = tesf_pkg::FC_W'(FMIN);
    end else begin
      fc_sat = fr[tesf_pkg::FC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_we) begin
      held_r[cmd.hold_idx] <= in_item.sample;
    end
    if (cmd.take_in) begin
      x_r <= in_item.sample;
    end else if (cmd.load_held) begin
      x_r <= held_r[cmd.hold_idx];
    end
    if (cmd.sum_ld) begin
      sum_r <= SUM_W'(held_r[0]) + SUM_W'(held_r[1]) + SUM_W'(held_r[2]);
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    case (cmd.acc_op)
      tesf_pkg::ACC_LOAD: acc_r <= prod_r;
      tesf_pkg::ACC_SUB:  acc_r <= acc_r - prod_r;
      tesf_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      tesf_pkg::ACC_FIN: begin
        b_r <= acc16;
        c_r <= p16;
        a_r <= a_nxt;
      end
      default: ;
    endcase
    if (cmd.fc_init) begin
      fsum_r  <= F_W'(a_r) + F_W'(b_r) + F_W'(c_r);
      delta_r <= F_W'(b_r) + F_W'(c_r) + (F_W'(c_r) <<< 1);
    end else if (cmd.fc_step) begin
      fsum_r  <= fsum_r + delta_r;
      delta_r <= delta_r + (F_W'(c_r) <<< 1);
    end
    if (cmd.out_ld) begin
      if (cmd.out_err) begin
        out_r.forecast    <= '0;
        out_r.horizon     <= 2'd0;
        out_r.too_short   <= 1'b1;
        out_r.last_result <= 1'b1;
      end else begin
        out_r.forecast    <= fc_sat;
        out_r.horizon     <= cmd.horizon;
        out_r.too_short   <= 1'b0;
        out_r.last_result <= (cmd.horizon == 2'd3);
      end
    end
  end

  // Smoothing levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= '0;
      l2_r <= '0;
      l3_r <= '0;
    end else if (cmd.lvl_clr) begin
      l1_r <= '0;
      l2_r <= '0;
      l3_r <= '0;
    end else begin
      case (cmd.acc_op)
        tesf_pkg::ACC_L1: l1_r <= l1_r + p16[tesf_pkg::LVL_W-1:0];
        tesf_pkg::ACC_L2: l2_r <= l2_r + p16[tesf_pkg::LVL_W-1:0];
        tesf_pkg::ACC_L3: l3_r <= l3_r + p16[tesf_pkg::LVL_W-1:0];
        tesf_pkg::ACC_MEAN: begin
          l1_r <= mean;
          l2_r <= mean;
          l3_r <= mean;
        end
        default: ;
      endcase
    end
  end

  assign out_item = out_r;

endmodule

// File: sv/triple_exponential_smoothing_forecast.sv
// Channel  Signals                               Dir   Handshake
// in       in_item (sample, last_sample)         in    in_valid / in_stall
// out      out_item (forecast, horizon, ...)     out   out_valid / out_stall
// cfg      cfg_index, cfg_wdata                  in    cfg_valid / cfg_ready
//
// A sample after the third is accepted, then multiplied and added for each
// of three smoothers on one shared multiplier. The first two are only held;
// the third adds sum, mean and replay of the held samples. A last sample
// adds the steps for a, b and c, then three forecasts or a too-short error.
// Synchronous reset (rst_n low) restores register defaults, clears the levels
// and sample count. A stalled result holds; only the next result waits on it.

module triple_exponential_smoothing_forecast (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tesf_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tesf_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tesf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tesf_pkg::WGT_W-1:0]          cfg_wdata
);

  tesf_pkg::dp_cmd_t cmd;
  logic              cfg_we;

  // User must write registers only while idle; unenforced, all writes taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequence samples, replay, forecast steps and result handoff
  tesf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last_sample),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Held samples, levels, shared multiplier, forecast terms, result register
  tesf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule

// File: tb/sv/forecast_checker.sv
`timescale 1ns / 1ps

module forecast_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  tesf_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  tesf_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tesf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tesf_pkg::WGT_W-1:0]     cfg_wdata,
  output int                             outstanding,
  output int                             mismatches
);

  localparam int REPORT_MAX = 10;
  localparam int SMP_W      = tesf_pkg::SMP_W;
  localparam int ALPHA_W    = tesf_pkg::ALPHA_W;
  localparam int WGT_W      = tesf_pkg::WGT_W;
  localparam int LVL_W      = tesf_pkg::LVL_W;
  localparam int FC_W       = tesf_pkg::FC_W;
  localparam int CFG_IDX_W  = tesf_pkg::CFG_IDX_W;

  // Shadow of the register file
  logic [ALPHA_W-1:0] alpha_r;
  logic [WGT_W-1:0]   bw_first;
  logic [WGT_W-1:0]   bw_second;
  logic [WGT_W-1:0]   bw_third;
  logic [WGT_W-1:0]   cw_quad;

  // Shadow of the series state
  logic [SMP_W-1:0] held [3];
  logic [LVL_W-1:0] lvl1;
  logic [LVL_W-1:0] lvl2;
  logic [LVL_W-1:0] lvl3;
  logic [1:0]       seen;

  tesf_pkg::out_item_t forecast_q [$];
  int                  errors = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  // One exponential smoother step, Q24.8 in and out
  function automatic logic [LVL_W-1:0] blend(input logic [63:0] x, input logic [63:0] prev);
    logic [63:0] w;
    logic [63:0] acc;
    w   = {48'd0, alpha_r};
    acc = w * x + (64'd65536 - w) * prev + 64'd32768;
    return acc[47:16];
  endfunction

  // Divide by 2^k, rounding halves toward plus infinity
  function automatic longint round_down_shift(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  task automatic smooth_all(input logic [SMP_W-1:0] s);
    logic [63:0] x;
    x    = {32'd0, s, 8'd0};
    lvl1 = blend(x, {32'd0, lvl1});
    lvl2 = blend({32'd0, lvl1}, {32'd0, lvl2});
    lvl3 = blend({32'd0, lvl2}, {32'd0, lvl3});
  endtask

  task automatic push_result(input longint fc, input logic [1:0] hz, input logic ts,
                             input logic lr);
    tesf_pkg::out_item_t r;
    r.forecast    = fc[FC_W-1:0];
    r.horizon     = hz;
    r.too_short   = ts;
    r.last_result = lr;
    forecast_q.push_back(r);
  endtask

  task automatic take_sample(input tesf_pkg::in_item_t it);
    logic [63:0] sum;
    logic [63:0] mean;
    longint      l1, l2, l3, b1, b2, b3, cq;
    longint      ca, cb, cc, f;
    if (seen < 2'd3) begin
      held[seen] = it.sample;
      seen       = seen + 2'd1;
      if (seen == 2'd3) begin
        // Seed all levels with the mean, then replay the held samples
        sum  = 64'(held[0]) + 64'(held[1]) + 64'(held[2]);
        mean = (sum * 64'd256 + 64'd1) / 64'd3;
        lvl1 = mean[LVL_W-1:0];
        lvl2 = mean[LVL_W-1:0];
        lvl3 = mean[LVL_W-1:0];
        for (int i = 0; i < 3; i++) smooth_all(held[i]);
      end
    end else begin
      smooth_all(it.sample);
    end

    if (it.last_sample) begin
      if (seen < 2'd3) begin
        push_result(0, 2'd0, 1'b1, 1'b1);
      end else begin
        l1 = lvl1;
        l2 = lvl2;
        l3 = lvl3;
        b1 = bw_first;
        b2 = bw_second;
        b3 = bw_third;
        cq = cw_quad;
        ca = 3 * l1 - 3 * l2 + l3;
        cb = round_down_shift(b1 * l1 - b2 * l2 + b3 * l3, 16);
        cc = round_down_shift(cq * (l1 - 2 * l2 + l3), 16);
        for (int m = 1; m <= 3; m++) begin
          f = round_down_shift(ca + m * cb + m * m * cc, 8);
          if (f > tesf_pkg::FC_MAX) f = tesf_pkg::FC_MAX;
          if (f < tesf_pkg::FC_MIN) f = tesf_pkg::FC_MIN;
          push_result(f, 2'(m), 1'b0, m == 3);
        end
      end
      seen = 2'd0;
      lvl1 = '0;
      lvl2 = '0;
      lvl3 = '0;
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WGT_W-1:0] val);
    case (tesf_pkg::cfg_idx_t'(idx))
      tesf_pkg::CFG_ALPHA: alpha_r   = val[ALPHA_W-1:0];
      tesf_pkg::CFG_BW1:   bw_first  = val;
      tesf_pkg::CFG_BW2:   bw_second = val;
      tesf_pkg::CFG_BW3:   bw_third  = val;
      tesf_pkg::CFG_CW:    cw_quad   = val;
      default:             ;
    endcase
  endtask

  task automatic check_result(input tesf_pkg::out_item_t got);
    tesf_pkg::out_item_t want;
    if (forecast_q.size() == 0) begin
      if (errors < REPORT_MAX)
        $display("%0t: unexpected result forecast=%0d horizon=%0d too_short=%0b last=%0b",
                 $realtime, got.forecast, got.horizon, got.too_short, got.last_result);
      errors++;
    end else begin
      want = forecast_q.pop_front();
      if (got.forecast !== want.forecast || got.horizon !== want.horizon ||
          got.too_short !== want.too_short || got.last_result !== want.last_result) begin
        if (errors < REPORT_MAX)
          $display({"%0t: mismatch exp forecast=%0d horizon=%0d too_short=%0b last=%0b,",
                    " got forecast=%0d horizon=%0d too_short=%0b last=%0b"},
                   $realtime, want.forecast, want.horizon, want.too_short,
                   want.last_result, got.forecast, got.horizon, got.too_short,
                   got.last_result);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   = tesf_pkg::ALPHA_RST;
      bw_first  = tesf_pkg::BW1_RST;
      bw_second = tesf_pkg::BW2_RST;
      bw_third  = tesf_pkg::BW3_RST;
      cw_quad   = tesf_pkg::CW_RST;
      for (int i = 0; i < 3; i++) held[i] = '0;
      lvl1 = '0;
      lvl2 = '0;
      lvl3 = '0;
      seen = 2'd0;
      forecast_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (in_valid && !in_stall) take_sample(in_item);
      if (cfg_valid && cfg_ready) write_cfg(cfg_index, cfg_wdata);
    end
    outstanding <= forecast_q.size();
    mismatches  <= errors;
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SMP_W     = tesf_pkg::SMP_W;
  localparam int ALPHA_W   = tesf_pkg::ALPHA_W;
  localparam int WGT_W     = tesf_pkg::WGT_W;
  localparam int CFG_IDX_W = tesf_pkg::CFG_IDX_W;

  // Cycles the block may still be busy after its last result
  localparam int SETTLE      = 48;
  // Watchdog, far beyond the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 20;
  localparam int IDLE_PCT    = 12;

  // Indexes past the end of the register list; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tesf_pkg::in_item_t   in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tesf_pkg::out_item_t  out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WGT_W-1:0]     cfg_wdata = '0;

  int   outstanding;
  int   mismatches;
  int   cycles = 0;
  logic calm   = 1'b0;   // set for a stretch with no idling on either side

  triple_exponential_smoothing_forecast i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  forecast_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the drain never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, about 12 percent of the time, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Offer one item and hold it until the edge that takes it. Every call
  // starts right after a rising edge, so valid gets one update per step.
  task automatic send_sample(input logic [SMP_W-1:0] s, input logic lst);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sample: s, last_sample: lst};
    do @(posedge clk); while (in_stall);
  endtask

  // Send a whole series; the final sample carries the last flag
  task automatic send_series(input logic [SMP_W-1:0] series[$]);
    foreach (series[i]) send_sample(series[i], i == series.size() - 1);
  endtask

  // Drop valid and wait until every predicted result has come out. The
  // checker's count is registered, so the loop waits on an edge first.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write one register and hold the request until the block takes it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WGT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a full register set while the block is idle; also poke a spare
  // index to check that the write is dropped. Alpha's upper data bits are
  // random and must be ignored.
  task automatic load_config(input logic [ALPHA_W-1:0] a, input logic [WGT_W-1:0] w1,
                             input logic [WGT_W-1:0] w2, input logic [WGT_W-1:0] w3,
                             input logic [WGT_W-1:0] wc);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
              WGT_W'($urandom()));
    write_reg(tesf_pkg::CFG_ALPHA, {8'($urandom()), a});
    write_reg(tesf_pkg::CFG_BW1, w1);
    write_reg(tesf_pkg::CFG_BW2, w2);
    write_reg(tesf_pkg::CFG_BW3, w3);
    write_reg(tesf_pkg::CFG_CW, wc);
    cfg_valid <= 1'b0;
  endtask

  // Mix of extremes, plausible factor sizes and anything at all
  function automatic logic [WGT_W-1:0] pick_weight();
    logic [WGT_W-1:0] w;
    case ($urandom_range(3))
      0:       w = '0;
      1:       w = '1;
      2:       w = WGT_W'($urandom_range(0, 400000));
      default: w = WGT_W'($urandom());
    endcase
    return w;
  endfunction

  // One random series. Most are well formed (three or more samples) so the
  // replay and forecast paths get exercised; some are too short.
  task automatic random_series(output int len);
    int               r;
    int               mode;
    logic [SMP_W-1:0] base;
    logic [SMP_W-1:0] step;
    logic [SMP_W-1:0] s;
    r = $urandom_range(99);
    if (r < 10)      len = $urandom_range(1, 2);
    else if (r < 80) len = $urandom_range(3, 8);
    else             len = $urandom_range(9, 20);
    mode = $urandom_range(2);
    base = SMP_W'($urandom());
    step = SMP_W'($urandom_range(0, 65535));
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = SMP_W'($urandom());
        1: s = base + step * SMP_W'(i);          // trending series, wraps freely
        default: begin
          case ($urandom_range(2))
            0:       s = '0;
            1:       s = '1;
            default: s = SMP_W'($urandom());
          endcase
        end
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin
    logic [SMP_W-1:0] series[$];
    int               len;
    int               done;
    logic             paused;

    // Hold reset low, then release it once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short series of one and two samples
    series = {24'hFFFFFF};
    send_series(series);
    series = {24'h000000, 24'hFFFFFF};
    send_series(series);
    // Exactly three samples: mean seed, replay and forecast on the same item
    series = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    send_series(series);
    series = {24'h000000, 24'h000000, 24'h000000, 24'h000000};
    send_series(series);
    series = {24'h000100, 24'h001000, 24'h010000, 24'h100000, 24'h800000};
    send_series(series);

    // Extreme weights on a jump: drive the forecast into positive saturation
    load_config('1, '1, '0, '1, '1);
    series = {24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF};
    send_series(series);
    // Only the subtracted factor, slowest smoothing: negative saturation
    load_config(16'd1, '0, '1, '0, '0);
    series = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
    send_series(series);

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_config(tesf_pkg::ALPHA_RST, tesf_pkg::BW1_RST, tesf_pkg::BW2_RST,
                       tesf_pkg::BW3_RST, tesf_pkg::CW_RST);
        1: load_config('0, pick_weight(), pick_weight(), pick_weight(), pick_weight());
        2: load_config(16'd1, pick_weight(), pick_weight(), pick_weight(), pick_weight());
        3: load_config('1, pick_weight(), pick_weight(), pick_weight(), pick_weight());
        default: load_config(ALPHA_W'($urandom_range(1, 65535)), pick_weight(),
                             pick_weight(), pick_weight(), pick_weight());
      endcase
      calm   = (p == 2);
      done   = 0;
      paused = 1'b0;
      while (done < PHASE_ITEMS) begin
        random_series(len);
        done += len;
        // Hold off mid-phase until all forecasts have come back
        if (p == 4 && !paused && done > PHASE_ITEMS / 3) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    calm = 1'b0;

    // Drain, let the block settle, then give the verdict
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
